/* hdl/smft_pkg.sv */
// Shared types and constants of the sparse matrix fast transpose block.
// Holds item structs, store entry layouts and the control/status bundles.
// No dependencies.
package smft_pkg;

	// Capacity and dimension limits
	localparam int MAX_TERMS = 63;
	localparam int MAX_DIM   = 64;

	// Field widths
	localparam int ROW_W = 6;
	localparam int COL_W = 6;
	localparam int VAL_W = 32;
	localparam int CFG_W = 7;
	localparam int OUT_W = 7;

	// Derived widths: store index, term count, active column count
	localparam int IDX_W = $clog2(MAX_TERMS);
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int DIM_W = $clog2(MAX_DIM + 1);

	// Configuration port
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_NUM_COLS = 1'b1;
	localparam logic [CFG_W-1:0] NUM_ROWS_RST = 7'd64;
	localparam logic [CFG_W-1:0] NUM_COLS_RST = 7'd64;

	// Input item
	typedef struct packed {
		logic [ROW_W-1:0]        term_row;
		logic [COL_W-1:0]        term_col;
		logic signed [VAL_W-1:0] term_value;
		logic                    no_term;
		logic                    last_term;
	} term_t;

	// Result item
	typedef struct packed {
		logic [OUT_W-1:0]        out_row;
		logic [OUT_W-1:0]        out_col;
		logic signed [VAL_W-1:0] out_value;
		logic                    is_header;
		logic                    overflow;
		logic                    last_result;
	} res_t;

	// Term store entry: rank is the term's place within its column
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [CNT_W-1:0] rank;
		logic [VAL_W-1:0] value;
	} ent_t;

	// Output buffer entry, already in transposed order
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [VAL_W-1:0] value;
	} obuf_t;

	// Controller to datapath
	typedef struct packed {
		logic term_ready;
		logic pass_init;
		logic pfx_run;
		logic pl_run;
		logic hdr_load;
		logic emit_run;
		logic clr_run;
		logic clr_restart;
		logic mat_reset;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic term_last;
		logic pfx_done;
		logic pl_done;
		logic slot_free;
		logic last_taken;
		logic clr_done;
	} sts_t;

endpackage

/* hdl/sparse_matrix_fast_transpose.sv */
// Sparse matrix fast transpose. Terms load one item per cycle into the term store.
// After the last item: a drain state, a prefix pass over the column RAM, a placement
// pass over the stored terms, then the header and the results from the output buffer,
// each result fetched through its registered read port before it is issued.
// Reset and the end of each placement pass start a clear sweep over all 64 column counts;
// after a placement it overlaps emission, and no item is taken until it ends.
module sparse_matrix_fast_transpose import smft_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               term_valid,
	output logic               term_ready,
	input  term_t              term,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res
);

	logic [CFG_W-1:0] num_rows;
	logic [CFG_W-1:0] num_cols;
	cmd_t             cmd;
	sts_t             sts;

	smft_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.num_rows (num_rows),
		.num_cols (num_cols)
	);

	smft_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	smft_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.num_rows   (num_rows),
		.num_cols   (num_cols),
		.term_valid (term_valid),
		.term       (term),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	assign term_ready = cmd.term_ready;

	// Loading never overlaps a pending result
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		term_ready |-> !res_valid)
		else $error("item taken while a result is pending");

	// Column counts are fully cleared before any item is taken
	a_load_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		term_ready |-> sts.clr_done)
		else $error("item taken before column clear finished");

	// Nothing follows the final result of a matrix
	a_nothing_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready && res.last_result) |=> !res_valid)
		else $error("result after final result");

endmodule

/* hdl/smft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/smft_regs.sv */
// Configuration registers (num_rows, num_cols) behind an APB-style port.
// Depends on smft_pkg.
module smft_regs import smft_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [CFG_W-1:0]   num_rows,
	output logic [CFG_W-1:0]   num_cols
);

	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	logic [CFG_W-1:0]     num_rows_q;
	logic [CFG_W-1:0]     num_cols_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	// Write on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= NUM_ROWS_RST;
			num_cols_q <= NUM_COLS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_NUM_ROWS: begin
					num_rows_q <= pwdata[CFG_W-1:0];
				end
				REG_NUM_COLS: begin
					num_cols_q <= pwdata[CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_NUM_ROWS: prdata = PDATA_W'(num_rows_q);
			REG_NUM_COLS: prdata = PDATA_W'(num_cols_q);
			default:      prdata = '0;
		endcase
	end

	assign num_rows = num_rows_q;
	assign num_cols = num_cols_q;

endmodule

/* hdl/smft_ctrl.sv */
// Controller state machine: clear, load, drain, prefix pass, placement pass, header, emission.
// Depends on smft_pkg.
module smft_ctrl import smft_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_CLEAR  = 7'b0000001,
		ST_LOAD   = 7'b0000010,
		ST_DRAIN  = 7'b0000100,
		ST_PREFIX = 7'b0001000,
		ST_PLACE  = 7'b0010000,
		ST_HEAD   = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_run = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.term_ready = 1'b1;
				if (sts.term_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.pass_init = 1'b1;
				state_d       = ST_PREFIX;
			end
			ST_PREFIX: begin
				cmd.pfx_run = 1'b1;
				if (sts.pfx_done) begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				cmd.pl_run = 1'b1;
				if (sts.pl_done) begin
					cmd.clr_restart = 1'b1;
					state_d         = ST_HEAD;
				end
			end
			ST_HEAD: begin
				cmd.hdr_load = 1'b1;
				cmd.clr_run  = 1'b1;
				if (sts.slot_free) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit_run = 1'b1;
				cmd.clr_run  = 1'b1;
				if (sts.last_taken) begin
					cmd.mat_reset = 1'b1;
					state_d       = ST_CLEAR;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/smft_dp.sv */
// Datapath: term store, column count / start RAM, output buffer, output register.
// Depends on smft_pkg and smft_ram.
module smft_dp import smft_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [CFG_W-1:0] num_rows,
	input  logic [CFG_W-1:0] num_cols,
	input  logic             term_valid,
	input  term_t            term,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	// Active column count
	logic [DIM_W-1:0] cols;
	assign cols = (num_cols < CFG_W'(MAX_DIM)) ? DIM_W'(num_cols) : DIM_W'(MAX_DIM);

	// Column RAM ports
	logic             cram_we;
	logic [COL_W-1:0] cram_waddr;
	logic [CNT_W-1:0] cram_wdata;
	logic [COL_W-1:0] cram_raddr;
	logic [CNT_W-1:0] cram_rdata;

	// Term store ports
	ent_t store_wdata;
	ent_t store_rdata;

	// Output buffer ports
	logic             obuf_we;
	logic [CNT_W-1:0] obuf_slot;
	obuf_t            obuf_wdata;
	obuf_t            obuf_rdata;

	// ---------------- load ----------------
	logic             fire;
	logic             take;
	logic             fits;
	logic             store_it;
	logic [CNT_W-1:0] cnt_q;
	logic             drop_q;
	logic             ld_vld_s1;
	logic [ROW_W-1:0] ld_row_s1;
	logic [COL_W-1:0] ld_col_s1;
	logic [VAL_W-1:0] ld_val_s1;
	logic [IDX_W-1:0] ld_idx_s1;
	logic [CNT_W-1:0] rank_s1;
	logic             wr_vld_q;
	logic [COL_W-1:0] wr_col_q;
	logic [CNT_W-1:0] wr_cnt_q;

	assign fire     = term_valid & cmd.term_ready;
	assign take     = fire & ~term.no_term;
	assign fits     = (DIM_W'(term.term_col) < cols) && (cnt_q < CNT_W'(MAX_TERMS));
	assign store_it = take & fits;

	// Count stored terms, flag dropped ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			drop_q    <= 1'b0;
			ld_vld_s1 <= 1'b0;
			wr_vld_q  <= 1'b0;
		end else begin
			if (cmd.mat_reset) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end else begin
				if (store_it) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (take && !fits) begin
					drop_q <= 1'b1;
				end
			end
			ld_vld_s1 <= store_it;
			wr_vld_q  <= ld_vld_s1;
		end
	end

	// Hold the accepted term for its count update
	always_ff @(posedge clk) begin
		ld_row_s1 <= term.term_row;
		ld_col_s1 <= term.term_col;
		ld_val_s1 <= term.term_value;
		ld_idx_s1 <= cnt_q[IDX_W-1:0];
		wr_col_q  <= ld_col_s1;
		wr_cnt_q  <= rank_s1 + CNT_W'(1);
	end

	// Forward the count just written when the same column follows
	assign rank_s1 = (wr_vld_q && (wr_col_q == ld_col_s1)) ? wr_cnt_q : cram_rdata;

	assign store_wdata = '{row: ld_row_s1, col: ld_col_s1, rank: rank_s1, value: ld_val_s1};

	// ---------------- prefix pass ----------------
	logic [DIM_W-1:0] pfx_idx_q;
	logic             pfx_vld_s1;
	logic [COL_W-1:0] pfx_col_s1;
	logic [CNT_W-1:0] acc_q;
	logic             pfx_issue;

	assign pfx_issue = cmd.pfx_run && (pfx_idx_q < cols);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfx_idx_q  <= '0;
			pfx_vld_s1 <= 1'b0;
			acc_q      <= '0;
		end else if (cmd.pass_init) begin
			pfx_idx_q  <= '0;
			pfx_vld_s1 <= 1'b0;
			acc_q      <= '0;
		end else begin
			pfx_vld_s1 <= pfx_issue;
			if (pfx_issue) begin
				pfx_idx_q <= pfx_idx_q + DIM_W'(1);
			end
			if (pfx_vld_s1) begin
				acc_q <= acc_q + cram_rdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		pfx_col_s1 <= pfx_idx_q[COL_W-1:0];
	end

	// ---------------- placement pass ----------------
	logic [CNT_W-1:0] pl_idx_q;
	logic             pl_vld_s1;
	logic             pl_vld_s2;
	ent_t             ent_s2;
	logic             pl_issue;

	assign pl_issue = cmd.pl_run && (pl_idx_q < cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pl_idx_q  <= '0;
			pl_vld_s1 <= 1'b0;
			pl_vld_s2 <= 1'b0;
		end else if (cmd.pass_init) begin
			pl_idx_q  <= '0;
			pl_vld_s1 <= 1'b0;
			pl_vld_s2 <= 1'b0;
		end else begin
			pl_vld_s1 <= pl_issue;
			pl_vld_s2 <= pl_vld_s1;
			if (pl_issue) begin
				pl_idx_q <= pl_idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_s2 <= store_rdata;
	end

	// Slot is the column start (zero based) plus the rank within the column
	assign obuf_we    = pl_vld_s2;
	assign obuf_slot  = cram_rdata + ent_s2.rank;
	assign obuf_wdata = '{col: ent_s2.col, row: ent_s2.row, value: ent_s2.value};

	// ---------------- column count clear sweep ----------------
	logic [DIM_W-1:0] clr_idx_q;
	logic             clr_wr;

	assign clr_wr = cmd.clr_run && (clr_idx_q < DIM_W'(MAX_DIM));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_restart) begin
			clr_idx_q <= '0;
		end else if (clr_wr) begin
			clr_idx_q <= clr_idx_q + DIM_W'(1);
		end
	end

	// ---------------- column RAM access ----------------
	always_comb begin
		if (cmd.pfx_run) begin
			cram_raddr = pfx_idx_q[COL_W-1:0];
		end else if (pl_vld_s1) begin
			cram_raddr = store_rdata.col;
		end else begin
			cram_raddr = term.term_col;
		end
	end

	always_comb begin
		cram_we    = 1'b0;
		cram_waddr = clr_idx_q[COL_W-1:0];
		cram_wdata = '0;
		if (ld_vld_s1) begin
			cram_we    = 1'b1;
			cram_waddr = ld_col_s1;
			cram_wdata = rank_s1 + CNT_W'(1);
		end else if (pfx_vld_s1) begin
			cram_we    = 1'b1;
			cram_waddr = pfx_col_s1;
			cram_wdata = acc_q;
		end else if (clr_wr) begin
			cram_we = 1'b1;
		end
	end

	// ---------------- emission ----------------
	logic             slot_free;
	logic             hdr_ld;
	logic             e_adv;
	logic [CNT_W-1:0] e_q;
	logic             fetch_q;
	logic             res_vld_q;
	res_t             res_q;

	assign slot_free = ~res_vld_q | res_ready;
	assign hdr_ld    = cmd.hdr_load & slot_free;
	assign e_adv     = cmd.emit_run && fetch_q && slot_free && (e_q < cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q       <= '0;
			fetch_q   <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			// Read data is good once the registered read port has sampled the held address
			fetch_q <= cmd.emit_run & ~e_adv;
			if (cmd.pass_init) begin
				e_q <= '0;
			end else if (e_adv) begin
				e_q <= e_q + CNT_W'(1);
			end
			if (hdr_ld || e_adv) begin
				res_vld_q <= 1'b1;
			end else if (res_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// Load the header or the next buffered term
	always_ff @(posedge clk) begin
		if (hdr_ld) begin
			res_q.out_row     <= OUT_W'(num_cols);
			res_q.out_col     <= OUT_W'(num_rows);
			res_q.out_value   <= VAL_W'(cnt_q);
			res_q.is_header   <= 1'b1;
			res_q.overflow    <= drop_q;
			res_q.last_result <= (cnt_q == '0);
		end else if (e_adv) begin
			res_q.out_row     <= OUT_W'(obuf_rdata.col);
			res_q.out_col     <= OUT_W'(obuf_rdata.row);
			res_q.out_value   <= obuf_rdata.value;
			res_q.is_header   <= 1'b0;
			res_q.overflow    <= 1'b0;
			res_q.last_result <= ((e_q + CNT_W'(1)) == cnt_q);
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

	// ---------------- status ----------------
	always_comb begin
		sts            = '0;
		sts.term_last  = fire & term.last_term;
		sts.pfx_done   = (pfx_idx_q >= cols) && !pfx_vld_s1;
		sts.pl_done    = (pl_idx_q >= cnt_q) && !pl_vld_s1 && !pl_vld_s2;
		sts.slot_free  = slot_free;
		sts.last_taken = res_vld_q & res_ready & res_q.last_result;
		sts.clr_done   = (clr_idx_q == DIM_W'(MAX_DIM));
	end

	// ---------------- memories ----------------
	smft_ram #(.WIDTH($bits(ent_t)), .DEPTH(MAX_TERMS)) u_store (
		.clk   (clk),
		.we    (ld_vld_s1),
		.waddr (ld_idx_s1),
		.wdata (store_wdata),
		.raddr (pl_idx_q[IDX_W-1:0]),
		.rdata (store_rdata)
	);

	smft_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DIM)) u_cram (
		.clk   (clk),
		.we    (cram_we),
		.waddr (cram_waddr),
		.wdata (cram_wdata),
		.raddr (cram_raddr),
		.rdata (cram_rdata)
	);

	smft_ram #(.WIDTH($bits(obuf_t)), .DEPTH(MAX_TERMS)) u_obuf (
		.clk   (clk),
		.we    (obuf_we),
		.waddr (obuf_slot[IDX_W-1:0]),
		.wdata (obuf_wdata),
		.raddr (e_q[IDX_W-1:0]),
		.rdata (obuf_rdata)
	);

endmodule
